// File: src/ldba_pkg.sv
package ldba_pkg;

  localparam int unsigned COLUMNS_DEF         = 4;
  localparam int unsigned LEDS_PER_COLUMN_DEF = 64;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned COL_W   = 2;
  localparam int unsigned LED_W   = 6;
  localparam int unsigned BRI_W   = 8;
  localparam int unsigned SW_W    = 4;
  localparam int unsigned SPEED_W = 14;
  localparam int unsigned FRAME_W = 7;
  localparam int unsigned PAL_W   = 5;

  localparam int unsigned LV_W  = 18;
  localparam int unsigned ST_W  = 18;
  localparam int unsigned SUM_W = 20;
  localparam int unsigned WORD_W = LV_W + ST_W + SW_W;

  // frame_ms * 5000 * 256 over anim_speed * (10 + led % 10)
  localparam int unsigned NUM_K     = 5000 * 256;
  localparam int unsigned NUM_W     = 28;
  localparam int unsigned DEN_W     = 19;
  localparam int unsigned QUOT_W    = 17;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  localparam int unsigned SPEED_MIN = 150;
  localparam int unsigned SPEED_RST = 150;
  localparam int unsigned FRAME_RST = 16;
  localparam int unsigned PAL_RST   = 1;
  localparam int unsigned PAL_MAX   = 16;
  localparam int unsigned LEVEL_K   = 10880;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INIT    = 2'd0,
    FUNC_ADVANCE = 2'd1,
    FUNC_RETIME  = 2'd2,
    FUNC_HOLD    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_ANIM_SPEED   = 2'd0,
    REG_FRAME_MS     = 2'd1,
    REG_PALETTE_SIZE = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WAIT
  } state_e;

  function automatic logic [1:0] mod3(logic [LED_W-1:0] x);
    logic [13:0] p;
    logic [4:0]  q;
    logic [5:0]  r;
    p = 14'(x) * 14'd171;
    q = p[13:9];
    r = x - 6'(q) * 6'd3;
    return r[1:0];
  endfunction

  function automatic logic [2:0] mod7(logic [LED_W:0] x);
    logic [15:0] p;
    logic [4:0]  q;
    logic [6:0]  r;
    p = 16'(x) * 16'd293;
    q = p[15:11];
    r = x - 7'(q) * 7'd7;
    return r[2:0];
  endfunction

  function automatic logic [3:0] mod10(logic [LED_W-1:0] x);
    logic [13:0] p;
    logic [2:0]  q;
    logic [5:0]  r;
    p = 14'(x) * 14'd205;
    q = p[13:11];
    r = x - 6'(q) * 6'd10;
    return r[3:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] bottom_limit(logic [LED_W-1:0] led);
    logic [1:0]       m;
    logic [SUM_W-1:0] mag;
    m   = led[1:0] + 2'd2;
    mag = (SUM_W'(210) + SUM_W'(m) * SUM_W'(30)) << 8;
    return -$signed(mag);
  endfunction

  function automatic logic signed [SUM_W-1:0] top_limit(logic [LED_W-1:0] led);
    logic [2:0]       m;
    logic [SUM_W-1:0] mag;
    m   = mod7(7'(led) + 7'd3);
    mag = (SUM_W'(255) + SUM_W'(m) * SUM_W'(30)) << 8;
    return $signed(mag);
  endfunction

  function automatic logic [LV_W-1:0] init_level(logic [COL_W-1:0] col,
                                                 logic [LED_W-1:0] led);
    logic [2:0] k;
    k = 3'(mod3(LED_W'(col))) + 3'(mod3(led));
    return LV_W'(k) * LV_W'(LEVEL_K);
  endfunction

endpackage

// File: src/ldba_ram.sv
module ldba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/ldba_div.sv
module ldba_div import ldba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [LED_W-1:0]   led_i,
  input  logic [SPEED_W-1:0] anim_speed_i,
  input  logic [FRAME_W-1:0] frame_ms_i,
  input  logic [PAL_W-1:0]   palette_size_i,
  output logic               done_o,
  output logic [QUOT_W-1:0]  quot_o,
  output logic [SW_W-1:0]    swatch_o
);

  logic              run_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [LED_W-1:0]  mled_q;
  logic [SW_W-1:0]   mrem_q;
  logic [PAL_W-1:0]  ps_q;

  logic [DEN_W:0]    trial;
  logic              qbit;
  logic [PAL_W-1:0]  mtrial;

  assign trial  = {rem_q, num_q[NUM_W-1]};
  assign qbit   = (trial >= (DEN_W+1)'(den_q));
  assign mtrial = {mrem_q, mled_q[LED_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        run_q  <= 1'b1;
        cnt_q  <= CNT_W'(DIV_STEPS);
        done_q <= 1'b0;
      end else if (run_q) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
        if (cnt_q == CNT_W'(1)) begin
          run_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= NUM_W'(frame_ms_i) * NUM_W'(NUM_K);
      den_q  <= DEN_W'(anim_speed_i) * DEN_W'(5'd10 + 5'(mod10(led_i)));
      rem_q  <= '0;
      mled_q <= led_i;
      mrem_q <= '0;
      ps_q   <= palette_size_i;
    end else if (run_q) begin
      // restoring step: quotient bits shift into the numerator from the right
      if (qbit) begin
        rem_q <= DEN_W'(trial - (DEN_W+1)'(den_q));
      end else begin
        rem_q <= trial[DEN_W-1:0];
      end
      num_q <= {num_q[NUM_W-2:0], qbit};
      // led % palette_size, one led bit per step over the first steps
      if (cnt_q > CNT_W'(DIV_STEPS - LED_W)) begin
        if (mtrial >= ps_q) begin
          mrem_q <= SW_W'(mtrial - ps_q);
        end else begin
          mrem_q <= mtrial[SW_W-1:0];
        end
        mled_q <= {mled_q[LED_W-2:0], 1'b0};
      end
    end
  end

  assign done_o   = done_q;
  assign quot_o   = num_q[QUOT_W-1:0];
  assign swatch_o = mrem_q;

endmodule

// File: src/led_dot_bounce_animator_top.sv
// Channel  | Direction | Handshake                   | Payload
// request  | in        | start & !busy               | func_i, column_i, led_index_i
// result   | out       | done_o, one cycle, no stall | out_column_o, out_led_o,
//          |           |                             | brightness_o, lit_o, swatch_o
// config   | in/out    | psel & penable & pwrite     | paddr, pwdata, prdata
//
// Advance, hold and off-grid requests: the result strobe is registered from the
// read state; the next request can be taken in the cycle the result shows.
// Init and retime: the result waits for the 28-step serial restoring divider.
// Dot state lives in one RAM word per dot, read then written back one request
// at a time. rst_ni resets control and config registers; RAM contents are not
// cleared. The result port cannot be stalled.
module led_dot_bounce_animator_top import ldba_pkg::*; #(
  parameter int unsigned COLUMNS         = COLUMNS_DEF,
  parameter int unsigned LEDS_PER_COLUMN = LEDS_PER_COLUMN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic [COL_W-1:0]   column_i,
  input  logic [LED_W-1:0]   led_index_i,

  output logic               done_o,
  output logic [COL_W-1:0]   out_column_o,
  output logic [LED_W-1:0]   out_led_o,
  output logic [BRI_W-1:0]   brightness_o,
  output logic               lit_o,
  output logic [SW_W-1:0]    swatch_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned DOTS   = COLUMNS * LEDS_PER_COLUMN;
  localparam int unsigned ADDR_W = (DOTS > 1) ? $clog2(DOTS) : 1;

  // config registers
  logic [SPEED_W-1:0] speed_q;
  logic [FRAME_W-1:0] frame_q;
  logic [PAL_W-1:0]   pal_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_W'(SPEED_RST);
      frame_q <= FRAME_W'(FRAME_RST);
      pal_q   <= PAL_W'(PAL_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ANIM_SPEED: begin
          speed_q <= (pwdata[SPEED_W-1:0] < SPEED_W'(SPEED_MIN)) ?
                     SPEED_W'(SPEED_MIN) : pwdata[SPEED_W-1:0];
        end
        REG_FRAME_MS: frame_q <= pwdata[FRAME_W-1:0];
        REG_PALETTE_SIZE: begin
          if (pwdata[PAL_W-1:0] == '0) begin
            pal_q <= PAL_W'(1);
          end else if (pwdata[PAL_W-1:0] > PAL_W'(PAL_MAX)) begin
            pal_q <= PAL_W'(PAL_MAX);
          end else begin
            pal_q <= pwdata[PAL_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ANIM_SPEED:   prdata = APB_DW'(speed_q);
      REG_FRAME_MS:     prdata = APB_DW'(frame_q);
      REG_PALETTE_SIZE: prdata = APB_DW'(pal_q);
      default:          prdata = '0;
    endcase
  end

  // request capture
  state_e             state_q, state_d;
  logic               accept;
  logic               in_grid;
  logic [ADDR_W-1:0]  in_addr;
  func_e              func_q;
  logic [COL_W-1:0]   col_q;
  logic [LED_W-1:0]   led_q;
  logic               grid_q;
  logic [ADDR_W-1:0]  addr_q;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start & ~busy;
  assign in_grid = (32'(column_i) < COLUMNS) && (32'(led_index_i) < LEDS_PER_COLUMN);
  assign in_addr = ADDR_W'(32'(column_i) * LEDS_PER_COLUMN + 32'(led_index_i));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      col_q  <= column_i;
      led_q  <= led_index_i;
      grid_q <= in_grid;
      addr_q <= in_addr;
    end
  end

  // divider for init and retime
  logic              div_start;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;
  logic [SW_W-1:0]   div_swatch;

  assign div_start = accept && in_grid &&
                     (func_e'(func_i) == FUNC_INIT || func_e'(func_i) == FUNC_RETIME);

  ldba_div u_div (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (div_start),
    .led_i          (led_index_i),
    .anim_speed_i   (speed_q),
    .frame_ms_i     (frame_q),
    .palette_size_i (pal_q),
    .done_o         (div_done),
    .quot_o         (div_quot),
    .swatch_o       (div_swatch)
  );

  // dot state memory: {colour, step, level}
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  ldba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  logic signed [LV_W-1:0]  rd_lv;
  logic signed [ST_W-1:0]  rd_st;
  logic [SW_W-1:0]         rd_ci;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lo_lim, hi_lim;
  logic [PAL_W-1:0]        ci_inc;

  assign rd_lv  = ram_rdata[LV_W-1:0];
  assign rd_st  = ram_rdata[LV_W+ST_W-1:LV_W];
  assign rd_ci  = ram_rdata[WORD_W-1:LV_W+ST_W];
  assign sum    = SUM_W'(rd_lv) + SUM_W'(rd_st);
  assign lo_lim = bottom_limit(led_q);
  assign hi_lim = top_limit(led_q);
  assign ci_inc = PAL_W'(rd_ci) + 1'b1;

  // level and colour kept across the divide for retime
  logic signed [LV_W-1:0] hold_lv_q;
  logic [SW_W-1:0]        hold_ci_q;
  logic                   hold_en;

  always_ff @(posedge clk_i) begin
    if (hold_en) begin
      hold_lv_q <= rd_lv;
      hold_ci_q <= rd_ci;
    end
  end

  logic signed [LV_W-1:0] new_lv;
  logic signed [ST_W-1:0] new_st;
  logic [SW_W-1:0]        new_ci;
  logic                   rep_en;
  logic                   rep_dark;

  assign ram_wdata = {new_ci, new_st, new_lv};

  always_comb begin
    state_d  = state_q;
    ram_we   = 1'b0;
    hold_en  = 1'b0;
    rep_en   = 1'b0;
    rep_dark = 1'b0;
    new_lv   = rd_lv;
    new_st   = rd_st;
    new_ci   = rd_ci;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (!grid_q) begin
          rep_en   = 1'b1;
          rep_dark = 1'b1;
          state_d  = S_IDLE;
        end else begin
          unique case (func_q)
            FUNC_ADVANCE: begin
              ram_we  = 1'b1;
              rep_en  = 1'b1;
              state_d = S_IDLE;
              if (rd_st < 0 && sum < lo_lim) begin
                new_lv = LV_W'(lo_lim);
                new_st = -rd_st;
                new_ci = (ci_inc >= pal_q) ? '0 : ci_inc[SW_W-1:0];
              end else if (rd_st > 0 && sum > hi_lim) begin
                new_lv = LV_W'(hi_lim);
                new_st = -rd_st;
              end else begin
                new_lv = sum[LV_W-1:0];
              end
            end
            FUNC_HOLD: begin
              rep_en  = 1'b1;
              state_d = S_IDLE;
            end
            default: begin
              hold_en = 1'b1;
              state_d = S_WAIT;
            end
          endcase
        end
      end
      S_WAIT: begin
        new_st = ST_W'(div_quot);
        if (func_q == FUNC_INIT) begin
          new_lv = init_level(col_q, led_q);
          new_ci = div_swatch;
        end else begin
          new_lv = hold_lv_q;
          new_ci = hold_ci_q;
        end
        if (div_done) begin
          ram_we  = 1'b1;
          rep_en  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // result registers
  logic             done_q;
  logic [COL_W-1:0] ocol_q;
  logic [LED_W-1:0] oled_q;
  logic [BRI_W-1:0] bri_q;
  logic             lit_q;
  logic [SW_W-1:0]  sw_q;
  logic             pos_lv;

  assign pos_lv = (new_lv > 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rep_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rep_en) begin
      ocol_q <= col_q;
      oled_q <= led_q;
      if (rep_dark || !pos_lv) begin
        bri_q <= '0;
        lit_q <= 1'b0;
      end else begin
        // positive level: integer part saturates at full scale
        bri_q <= (new_lv[LV_W-2:BRI_W+8] != '0) ? '1 : new_lv[BRI_W+7:8];
        lit_q <= 1'b1;
      end
      sw_q <= rep_dark ? '0 : new_ci;
    end
  end

  assign done_o       = done_q;
  assign out_column_o = ocol_q;
  assign out_led_o    = oled_q;
  assign brightness_o = bri_q;
  assign lit_o        = lit_q;
  assign swatch_o     = sw_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q != S_IDLE))
    else $error("result strobe without a request in flight");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_WAIT)
    else $error("divider finished outside the wait state");

  a_write_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> done_o)
    else $error("dot written without a result");

  a_dark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !lit_o |-> brightness_o == '0)
    else $error("dark dot reported with brightness");

endmodule
